// File: design/ppv_pkg.sv
// ----------------------------------------------------------------------------
// ppv_pkg
// Types, constants and helper functions of the viewport projection block.
// ----------------------------------------------------------------------------
package ppv_pkg;

    localparam int CfgRegs  = 8;
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 64;
    localparam int DimW     = 14;
    localparam int ProdW    = 64;
    localparam int SumW     = 66;
    localparam int ClipW    = 50;
    localparam int RemW     = 50;
    localparam int NumW     = 64;
    localparam int DivNW    = 80;
    localparam int QW       = 34;
    localparam int ResW     = 36;
    localparam int FracBits = 16;

    localparam logic [CfgDataW-1:0] OneQ16   = 64'h0000_0000_0001_0000;
    localparam logic [CfgDataW-1:0] OneQ16Hi = 64'h0001_0000_0000_0000;
    localparam logic [QW-1:0]       TMax     = 34'h2_0000_0000;
    localparam logic [RemW-1:0]     AOne     = 50'h1_0000;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [DimW-1:0]    viewport_width;
        logic [DimW-1:0]    viewport_height;
    } t_in;

    typedef struct packed {
        logic signed [31:0] screen_x;
        logic signed [31:0] screen_y;
        logic               in_front;
        logic               saturated;
    } t_out;

    typedef struct packed {
        logic            neg;
        logic            ovf;
        logic [DimW-1:0] dim;
        logic [RemW-1:0] rem;
        logic [QW-1:0]   nlo;
        logic [QW-1:0]   q;
    } t_lane;

    typedef struct packed {
        logic            valid;
        logic            front;
        logic [RemW-1:0] a;
        t_lane           x;
        t_lane           y;
    } t_div;

    function automatic t_lane div_step(input t_lane l, input logic [RemW-1:0] a);
        t_lane         r;
        logic [RemW:0] rs;
        r  = l;
        rs = {l.rem, l.nlo[QW-1]};
        if (rs >= {1'b0, a}) begin
            r.rem = RemW'(rs - {1'b0, a});
            r.q   = {l.q[QW-2:0], 1'b1};
        end else begin
            r.rem = rs[RemW-1:0];
            r.q   = {l.q[QW-2:0], 1'b0};
        end
        r.nlo = {l.nlo[QW-2:0], 1'b0};
        return r;
    endfunction

    function automatic t_lane div_init(input logic neg, input logic [DimW-1:0] dim,
                                       input logic [NumW-1:0] n,
                                       input logic [RemW-1:0] a);
        t_lane            r;
        logic [DivNW-1:0] big;
        big   = {1'b0, n, 15'd0} + {30'd0, 1'b0, a[RemW-1:1]};
        r.neg = neg;
        r.dim = dim;
        r.ovf = ({4'd0, big[DivNW-1:QW]} >= a);
        r.rem = {4'd0, big[DivNW-1:QW]};
        r.nlo = big[QW-1:0];
        r.q   = '0;
        return r;
    endfunction

    function automatic logic [32:0] finish(input t_lane l, input logic sub);
        logic [QW-1:0]          t;
        logic signed [ResW-1:0] st;
        logic signed [ResW-1:0] base;
        logic signed [ResW-1:0] s;
        logic [32:0]            r;
        t    = (l.ovf || l.q > TMax) ? TMax : l.q;
        st   = l.neg ? -$signed({2'b00, t}) : $signed({2'b00, t});
        base = $signed({7'd0, l.dim, 15'd0});
        s    = sub ? base - st : base + st;
        if (s > $signed(ResW'(32'h7FFF_FFFF))) begin
            r = {1'b1, 32'h7FFF_FFFF};
        end else if (s < -$signed(ResW'(32'h8000_0000))) begin
            r = {1'b1, 32'h8000_0000};
        end else begin
            r = {1'b0, s[31:0]};
        end
        return r;
    endfunction

endpackage

// File: design/perspective_project_to_viewport.sv
// ----------------------------------------------------------------------------
// perspective_project_to_viewport
// Point times the x, y and w columns of a 4x4 matrix, perspective scale and viewport mapping in Q16.16.
// ----------------------------------------------------------------------------
// The block accepts one point per cycle unless the output stalls. A point
// passes input, product, sum, operand and setup registers, the 34-stage
// restoring divider that forms the perspective scale, one quotient bit per
// stage, and the output register. A stall on the output freezes the pipeline.
module perspective_project_to_viewport (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [ppv_pkg::CfgIdxW-1:0]    i_cfg_idx,
    input  logic [ppv_pkg::CfgDataW-1:0]   i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  ppv_pkg::t_in                   i_data,
    output logic                           o_valid,
    input  logic                           i_stall,
    output ppv_pkg::t_out                  o_data
);

    logic                                  en;
    logic [ppv_pkg::CfgDataW-1:0]          r_mat [ppv_pkg::CfgRegs];

    logic                                  r_s0_valid;
    ppv_pkg::t_in                          r_s0;

    logic                                  r_s1_valid;
    logic signed [ppv_pkg::ProdW-1:0]      r_px [3];
    logic signed [ppv_pkg::ProdW-1:0]      r_py [3];
    logic signed [ppv_pkg::ProdW-1:0]      r_pw [3];
    logic [ppv_pkg::DimW-1:0]              r_s1_w, r_s1_h;
    logic signed [ppv_pkg::ProdW-1:0]      n_px [3];
    logic signed [ppv_pkg::ProdW-1:0]      n_py [3];
    logic signed [ppv_pkg::ProdW-1:0]      n_pw [3];

    logic                                  r_s2_valid;
    logic signed [ppv_pkg::ClipW-1:0]      r_cx, r_cy, r_cw;
    logic [ppv_pkg::DimW-1:0]              r_s2_w, r_s2_h;
    logic signed [ppv_pkg::SumW-1:0]       n_sx, n_sy, n_sw;

    logic                                  r_s3_valid;
    logic [ppv_pkg::RemW-1:0]              r_a;
    logic [ppv_pkg::NumW-1:0]              r_nx, r_ny;
    logic                                  r_negx, r_negy, r_front;
    logic [ppv_pkg::DimW-1:0]              r_s3_w, r_s3_h;
    logic [ppv_pkg::RemW-1:0]              n_a, n_magx, n_magy;

    ppv_pkg::t_div                         r_s4, n_s4;
    ppv_pkg::t_div                         r_div [ppv_pkg::QW];
    ppv_pkg::t_div                         n_div [ppv_pkg::QW];

    logic                                  r_out_valid;
    ppv_pkg::t_out                         r_out, n_out;
    logic [32:0]                           n_fx, n_fy;

    assign en      = !(r_out_valid && i_stall);
    assign o_stall = !en;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mat[0] <= ppv_pkg::OneQ16;
            r_mat[1] <= '0;
            r_mat[2] <= ppv_pkg::OneQ16Hi;
            r_mat[3] <= '0;
            r_mat[4] <= '0;
            r_mat[5] <= ppv_pkg::OneQ16;
            r_mat[6] <= '0;
            r_mat[7] <= ppv_pkg::OneQ16Hi;
        end else if (i_cfg_we) begin
            r_mat[i_cfg_idx] <= i_cfg_data;
        end
    end

    always_comb begin
        n_px[0] = 64'(r_s0.pos_x * $signed(r_mat[0][31:0]));
        n_px[1] = 64'(r_s0.pos_y * $signed(r_mat[2][31:0]));
        n_px[2] = 64'(r_s0.pos_z * $signed(r_mat[4][31:0]));
        n_py[0] = 64'(r_s0.pos_x * $signed(r_mat[0][63:32]));
        n_py[1] = 64'(r_s0.pos_y * $signed(r_mat[2][63:32]));
        n_py[2] = 64'(r_s0.pos_z * $signed(r_mat[4][63:32]));
        n_pw[0] = 64'(r_s0.pos_x * $signed(r_mat[1][63:32]));
        n_pw[1] = 64'(r_s0.pos_y * $signed(r_mat[3][63:32]));
        n_pw[2] = 64'(r_s0.pos_z * $signed(r_mat[5][63:32]));

        n_sx = ppv_pkg::SumW'(r_px[0]) + ppv_pkg::SumW'(r_px[1])
             + ppv_pkg::SumW'(r_px[2])
             + (ppv_pkg::SumW'($signed(r_mat[6][31:0])) <<< ppv_pkg::FracBits);
        n_sy = ppv_pkg::SumW'(r_py[0]) + ppv_pkg::SumW'(r_py[1])
             + ppv_pkg::SumW'(r_py[2])
             + (ppv_pkg::SumW'($signed(r_mat[6][63:32])) <<< ppv_pkg::FracBits);
        n_sw = ppv_pkg::SumW'(r_pw[0]) + ppv_pkg::SumW'(r_pw[1])
             + ppv_pkg::SumW'(r_pw[2])
             + (ppv_pkg::SumW'($signed(r_mat[7][63:32])) <<< ppv_pkg::FracBits);

        n_a    = (r_cw == '0) ? ppv_pkg::AOne
               : (r_cw[ppv_pkg::ClipW-1] ? ppv_pkg::RemW'(-r_cw) : ppv_pkg::RemW'(r_cw));
        n_magx = r_cx[ppv_pkg::ClipW-1] ? ppv_pkg::RemW'(-r_cx) : ppv_pkg::RemW'(r_cx);
        n_magy = r_cy[ppv_pkg::ClipW-1] ? ppv_pkg::RemW'(-r_cy) : ppv_pkg::RemW'(r_cy);

        n_s4.valid = r_s3_valid;
        n_s4.front = r_front;
        n_s4.a     = r_a;
        n_s4.x     = ppv_pkg::div_init(r_negx, r_s3_w, r_nx, r_a);
        n_s4.y     = ppv_pkg::div_init(r_negy, r_s3_h, r_ny, r_a);

        for (int k = 0; k < ppv_pkg::QW; k++) begin
            if (k == 0) begin
                n_div[k]   = r_s4;
            end else begin
                n_div[k]   = r_div[k-1];
            end
            n_div[k].x = ppv_pkg::div_step(n_div[k].x, n_div[k].a);
            n_div[k].y = ppv_pkg::div_step(n_div[k].y, n_div[k].a);
        end

        n_fx = ppv_pkg::finish(r_div[ppv_pkg::QW-1].x, 1'b0);
        n_fy = ppv_pkg::finish(r_div[ppv_pkg::QW-1].y, 1'b1);
        n_out.screen_x  = n_fx[31:0];
        n_out.screen_y  = n_fy[31:0];
        n_out.in_front  = r_div[ppv_pkg::QW-1].front;
        n_out.saturated = n_fx[32] | n_fy[32];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid  <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_s4.valid  <= 1'b0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < ppv_pkg::QW; k++) begin
                r_div[k].valid <= 1'b0;
            end
        end else if (en) begin
            r_s0_valid  <= i_valid;
            r_s1_valid  <= r_s0_valid;
            r_s2_valid  <= r_s1_valid;
            r_s3_valid  <= r_s2_valid;
            r_out_valid <= r_div[ppv_pkg::QW-1].valid;
            r_s0 <= i_data;
            for (int k = 0; k < 3; k++) begin
                r_px[k] <= n_px[k];
                r_py[k] <= n_py[k];
                r_pw[k] <= n_pw[k];
            end
            r_s1_w  <= r_s0.viewport_width;
            r_s1_h  <= r_s0.viewport_height;
            r_cx    <= n_sx[ppv_pkg::ClipW+ppv_pkg::FracBits-1:ppv_pkg::FracBits];
            r_cy    <= n_sy[ppv_pkg::ClipW+ppv_pkg::FracBits-1:ppv_pkg::FracBits];
            r_cw    <= n_sw[ppv_pkg::ClipW+ppv_pkg::FracBits-1:ppv_pkg::FracBits];
            r_s2_w  <= r_s1_w;
            r_s2_h  <= r_s1_h;
            r_a     <= n_a;
            r_nx    <= ppv_pkg::NumW'(n_magx * r_s2_w);
            r_ny    <= ppv_pkg::NumW'(n_magy * r_s2_h);
            r_negx  <= r_cx[ppv_pkg::ClipW-1];
            r_negy  <= r_cy[ppv_pkg::ClipW-1];
            r_front <= !r_cw[ppv_pkg::ClipW-1];
            r_s3_w  <= r_s2_w;
            r_s3_h  <= r_s2_h;
            r_s4    <= n_s4;
            for (int k = 0; k < ppv_pkg::QW; k++) begin
                r_div[k] <= n_div[k];
            end
            r_out <= n_out;
        end
    end

endmodule
